// ===== rtl/core/gmeu_pkg.sv =====
// Shared types, constants and saturation helpers for the gravity momentum and energy update.
// Used by every module of the block; depends on nothing else.

package gmeu_pkg;

    // Patch geometry.
    localparam int CELLS_PER_SIDE = 8;
    localparam int GHOST_WIDTH    = 2;
    localparam int CUBE_SIDE      = CELLS_PER_SIDE + 2 * GHOST_WIDTH;
    localparam int CUBE_WORDS     = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
    localparam int ADDR_W         = $clog2(CUBE_WORDS);
    localparam int OFS_W          = ADDR_W + 1;
    localparam bit FIVE_OK        = (GHOST_WIDTH >= 2);

    // Field widths.
    localparam int COORD_W = 4;
    localparam int WORD_W  = 32;
    localparam int RHO_W   = 31;
    localparam int DIFF_W  = 38;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 72;
    localparam int GAIN_W  = 48;
    localparam int H_W     = 50;
    localparam int H_LO_W  = 24;
    localparam int WIDE_W  = 82;
    localparam int DOT_W   = 64;

    // Input beat layout on s_tdata.
    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = POS_X_LSB + COORD_W;
    localparam int POS_Z_LSB   = POS_Y_LSB + COORD_W;
    localparam int POT_LSB     = POS_Z_LSB + COORD_W;
    localparam int RHO_LSB     = POT_LSB + WORD_W;
    localparam int MOM_X_LSB   = RHO_LSB + RHO_W;
    localparam int MOM_Y_LSB   = MOM_X_LSB + WORD_W;
    localparam int MOM_Z_LSB   = MOM_Y_LSB + WORD_W;
    localparam int ENERGY_LSB  = MOM_Z_LSB + WORD_W;
    localparam int IN_BITS     = ENERGY_LSB + WORD_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = 4 * WORD_W;

    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [MUL_W-1:0]   mul_op_t;
    typedef logic signed [PROD_W-1:0]  mul_prod_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [H_W-1:0]     half_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [DOT_W-1:0]   dword_t;

    typedef diff_t diff_arr_t [3];
    typedef word_t word_arr_t [3];

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PROC = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_GRAV_SCALE = 1'b0,
        REG_FIVE_POINT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // Neighbor taps along one axis: two below, one below, one above, two above.
    typedef enum logic [1:0] {
        TAP_M2,
        TAP_M1,
        TAP_P1,
        TAP_P2
    } tap_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_GATHER,
        TS_ARITH,
        TS_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        GA_IDLE,
        GA_READ,
        GA_WAIT,
        GA_DONE
    } gather_state_t;

    typedef enum logic [3:0] {
        AR_IDLE,
        AR_MUL_LO,
        AR_MUL_HI,
        AR_ACC,
        AR_MUL_RHO,
        AR_GAIN,
        AR_MUL_HLO,
        AR_MUL_HHI,
        AR_PROD,
        AR_DOT,
        AR_RND,
        AR_ENERGY,
        AR_DONE
    } arith_state_t;

    // Signed word offset from a cell to one of its neighbors.
    function automatic logic signed [OFS_W-1:0] tap_offset(input axis_t axis, input tap_t tap);
        logic signed [OFS_W-1:0] stride;
        logic signed [OFS_W-1:0] ofs;
        case (axis)
            AXIS_X:  stride = OFS_W'(1);
            AXIS_Y:  stride = OFS_W'(CUBE_SIDE);
            default: stride = OFS_W'(CUBE_SIDE * CUBE_SIDE);
        endcase
        case (tap)
            TAP_M2:  ofs = -(stride <<< 1);
            TAP_M1:  ofs = -stride;
            TAP_P1:  ofs = stride;
            default: ofs = stride <<< 1;
        endcase
        return ofs;
    endfunction

    // Clamp a wide signed value to a signed 32-bit word.
    function automatic word_t sat32(input wide_t v);
        logic [WIDE_W-WORD_W:0] top;
        top = v[WIDE_W-1:WORD_W-1];
        if ((top == '0) || (top == '1))
            return v[WORD_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // Clamp a wide signed value to a signed 64-bit word.
    function automatic dword_t sat64(input wide_t v);
        logic [WIDE_W-DOT_W:0] top;
        top = v[WIDE_W-1:DOT_W-1];
        if ((top == '0) || (top == '1))
            return v[DOT_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(DOT_W-1){1'b0}}};
        else
            return {1'b0, {(DOT_W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/core/gravity_momentum_energy_update.sv =====
// Top level of the gravity source-term block: configuration port, stream ports and control.
// Depends on gmeu_pkg, gmeu_pot_mem, gmeu_gather and gmeu_arith.

// A load beat (tuser 0) writes one word of the 12x12x12 potential cube, ghost zone included;
// loads with a coordinate outside the cube are dropped. A process beat (tuser 1) gives one
// interior cell and returns one beat of updated momenta and energy: the neighbors are read
// one per cycle from the single read port of the potential memory (6 or 12 reads, in
// two-point or five-point mode), and one shared 33x33 multiplier then forms five products per
// axis, followed by the energy rounding. One item is worked on at a time; input is taken
// again once the result sits in the output register. Process beats outside the interior give
// no result. Reading a cube word that was never loaded gives an undefined result. Write
// grav_scale and five_point_mode only while the block is idle.

module gravity_momentum_energy_update (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, potential, density, mom_x_in, mom_y_in, mom_z_in, energy_in, pad
    input  logic [207:0] s_tdata,
    // opcode
    input  logic         s_tuser,
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // mom_x_out, mom_y_out, mom_z_out, energy_out
    output logic [127:0] m_tdata
);
    import gmeu_pkg::*;

    top_state_t state_reg, state_next;

    logic [31:0] grav_scale_reg;
    logic        five_point_reg;
    logic [30:0] rho_reg;
    word_arr_t   mom_reg;
    word_t       energy_reg;
    logic        m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic       accept;
    logic       cfg_write;
    coord_t     pos_x, pos_y, pos_z;
    logic       in_cube;
    logic       in_interior;
    addr_t      load_addr;
    addr_t      center_addr;
    logic       mem_we;
    logic       mem_re;
    addr_t      mem_raddr;
    word_t      mem_rdata;
    logic       g_start;
    logic       g_done;
    diff_arr_t  diff;
    logic       a_start;
    logic       a_done;
    word_arr_t  mom_out;
    word_t      energy_out;
    logic       out_load;

    // Field extraction.
    assign pos_x = s_tdata[POS_X_LSB +: COORD_W];
    assign pos_y = s_tdata[POS_Y_LSB +: COORD_W];
    assign pos_z = s_tdata[POS_Z_LSB +: COORD_W];

    assign in_cube = (int'(pos_x) < CUBE_SIDE) && (int'(pos_y) < CUBE_SIDE)
                     && (int'(pos_z) < CUBE_SIDE);
    assign in_interior = (int'(pos_x) < CELLS_PER_SIDE) && (int'(pos_y) < CELLS_PER_SIDE)
                         && (int'(pos_z) < CELLS_PER_SIDE);

    assign load_addr = ADDR_W'((int'(pos_z) * CUBE_SIDE + int'(pos_y)) * CUBE_SIDE
                               + int'(pos_x));
    assign center_addr = ADDR_W'(((int'(pos_z) + GHOST_WIDTH) * CUBE_SIDE
                                  + int'(pos_y) + GHOST_WIDTH) * CUBE_SIDE
                                 + int'(pos_x) + GHOST_WIDTH);

    assign accept  = s_tvalid && s_tready;
    assign mem_we  = accept && (s_tuser == OP_LOAD) && in_cube;
    assign g_start = accept && (s_tuser == OP_PROC) && in_interior;
    assign a_start = (state_reg == TS_GATHER) && g_done;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (g_start)
                    state_next = TS_GATHER;
            end
            TS_GATHER:
            begin
                if (g_done)
                    state_next = TS_ARITH;
            end
            TS_ARITH:
            begin
                if (a_done)
                    state_next = TS_OUT;
            end
            TS_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            TS_IDLE: s_tready = 1'b1;
            TS_OUT:  out_load = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_GRAV_SCALE) ? grav_scale_reg : {31'b0, five_point_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_scale_reg <= '0;
            five_point_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_GRAV_SCALE)
                grav_scale_reg <= pwdata;
            else
                five_point_reg <= pwdata[0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= TS_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Cell operands and output beat.
    always_ff @(posedge clk)
    begin
        if (g_start)
        begin
            rho_reg    <= s_tdata[RHO_LSB +: RHO_W];
            mom_reg[0] <= s_tdata[MOM_X_LSB +: WORD_W];
            mom_reg[1] <= s_tdata[MOM_Y_LSB +: WORD_W];
            mom_reg[2] <= s_tdata[MOM_Z_LSB +: WORD_W];
            energy_reg <= s_tdata[ENERGY_LSB +: WORD_W];
        end
        if (out_load)
        begin
            m_tdata_reg <= {energy_out, mom_out[2], mom_out[1], mom_out[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    gmeu_pot_mem u_pot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (load_addr),
        .wdata (s_tdata[POT_LSB +: WORD_W]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gmeu_gather u_gather (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (g_start),
        .center  (center_addr),
        .five    (five_point_reg && FIVE_OK),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .diff    (diff),
        .done    (g_done)
    );

    gmeu_arith u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (a_start),
        .grav_scale (grav_scale_reg),
        .density    (rho_reg),
        .diff       (diff),
        .mom_in     (mom_reg),
        .energy_in  (energy_reg),
        .mom_out    (mom_out),
        .energy_out (energy_out),
        .done       (a_done)
    );

    // Neighbor reads happen only while a cell is being gathered.
    assert property (@(posedge clk) disable iff (!rst_n) mem_re |-> state_reg == TS_GATHER)
        else $error("potential read outside the gather phase");

    // The gather and the arithmetic finish only in their own phases.
    assert property (@(posedge clk) disable iff (!rst_n) g_done |-> state_reg == TS_GATHER)
        else $error("gather finished outside the gather phase");

    assert property (@(posedge clk) disable iff (!rst_n) a_done |-> state_reg == TS_ARITH)
        else $error("arithmetic finished outside the arithmetic phase");

    // A new result never replaces one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while stalled");

endmodule

// ===== rtl/core/gmeu_pot_mem.sv =====
// Potential cube storage: one write port, one read port with registered read data.
// Depends on gmeu_pkg for the address and word types.

module gmeu_pot_mem (
    input  logic            clk,
    input  logic            we,
    input  gmeu_pkg::addr_t waddr,
    input  gmeu_pkg::word_t wdata,
    input  logic            re,
    input  gmeu_pkg::addr_t raddr,
    output gmeu_pkg::word_t rdata
);
    import gmeu_pkg::*;

    word_t mem [CUBE_WORDS];
    word_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gmeu_gather.sv =====
// Neighbor read sequencer: walks the taps of all three axes through the potential memory
// and accumulates the central differences. Depends on gmeu_pkg.

module gmeu_gather (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  gmeu_pkg::addr_t       center,
    input  logic                  five,
    output logic                  rd_en,
    output gmeu_pkg::addr_t       rd_addr,
    input  gmeu_pkg::word_t       rd_data,
    output gmeu_pkg::diff_arr_t   diff,
    output logic                  done
);
    import gmeu_pkg::*;

    gather_state_t state_reg, state_next;
    addr_t         ctr_reg;
    axis_t         axis_reg;
    tap_t          tap_reg;
    logic          five_reg;
    logic          pend_reg;
    axis_t         pend_axis_reg;
    tap_t          pend_tap_reg;
    diff_arr_t     diff_reg;

    tap_t                    first_tap;
    tap_t                    last_tap;
    logic                    axis_end;
    logic                    sweep_end;
    axis_t                   axis_inc;
    logic signed [OFS_W-1:0] addr_sum;
    diff_t                   term_ext;
    diff_t                   term;
    logic                    term_neg;

    assign first_tap = five_reg ? TAP_M2 : TAP_M1;
    assign last_tap  = five_reg ? TAP_P2 : TAP_P1;
    assign axis_end  = (tap_reg == last_tap);
    assign sweep_end = axis_end && (axis_reg == AXIS_Z);

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  axis_inc = AXIS_Y;
            default: axis_inc = AXIS_Z;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GA_IDLE:
            begin
                if (start)
                    state_next = GA_READ;
            end
            GA_READ:
            begin
                if (sweep_end)
                    state_next = GA_WAIT;
            end
            GA_WAIT: state_next = GA_DONE;
            GA_DONE: state_next = GA_IDLE;
            default: state_next = GA_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        rd_en = 1'b0;
        done  = 1'b0;
        case (state_reg)
            GA_READ: rd_en = 1'b1;
            GA_DONE: done  = 1'b1;
            default:
            begin
                rd_en = 1'b0;
                done  = 1'b0;
            end
        endcase
    end

    // Neighbor address: center plus a signed stride multiple.
    assign addr_sum = $signed({1'b0, ctr_reg}) + tap_offset(axis_reg, tap_reg);
    assign rd_addr  = addr_sum[ADDR_W-1:0];

    // Tap weight: +1, -8, +8, -1 for five points, -1, +1 for two.
    assign term_ext = DIFF_W'(rd_data);
    assign term     = (five_reg && ((pend_tap_reg == TAP_M1) || (pend_tap_reg == TAP_P1)))
                      ? (term_ext <<< 3) : term_ext;
    assign term_neg = (pend_tap_reg == TAP_M1) || (pend_tap_reg == TAP_P2);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GA_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
        end
    end

    // Tap walk and difference accumulation.
    always_ff @(posedge clk)
    begin
        pend_axis_reg <= axis_reg;
        pend_tap_reg  <= tap_reg;
        if ((state_reg == GA_IDLE) && start)
        begin
            ctr_reg     <= center;
            five_reg    <= five;
            axis_reg    <= AXIS_X;
            tap_reg     <= five ? TAP_M2 : TAP_M1;
            diff_reg[0] <= '0;
            diff_reg[1] <= '0;
            diff_reg[2] <= '0;
        end
        else
        begin
            if (state_reg == GA_READ)
            begin
                if (axis_end)
                begin
                    tap_reg  <= first_tap;
                    axis_reg <= axis_inc;
                end
                else
                begin
                    tap_reg <= tap_t'(tap_reg + 2'd1);
                end
            end
            if (pend_reg)
            begin
                if (term_neg)
                    diff_reg[pend_axis_reg] <= diff_reg[pend_axis_reg] - term;
                else
                    diff_reg[pend_axis_reg] <= diff_reg[pend_axis_reg] + term;
            end
        end
    end

    assign diff = diff_reg;

endmodule

// ===== rtl/core/gmeu_arith.sv =====
// Shared-multiplier sequencer that turns the three differences into accelerations and
// applies the momentum and energy updates with saturation. Depends on gmeu_pkg.

module gmeu_arith (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           grav_scale,
    input  logic [30:0]           density,
    input  gmeu_pkg::diff_arr_t   diff,
    input  gmeu_pkg::word_arr_t   mom_in,
    input  gmeu_pkg::word_t       energy_in,
    output gmeu_pkg::word_arr_t   mom_out,
    output gmeu_pkg::word_t       energy_out,
    output logic                  done
);
    import gmeu_pkg::*;

    arith_state_t state_reg, state_next;
    axis_t        axis_reg;
    mul_prod_t    mul_reg;
    mul_prod_t    lo_reg;
    word_t        acc_reg;
    half_t        h_reg;
    dword_t       psat_reg;
    dword_t       dot_reg;
    gain_t        rdot_reg;
    word_arr_t    mom_out_reg;
    word_t        energy_out_reg;

    mul_op_t                  mul_a;
    mul_op_t                  mul_b;
    diff_t                    d_sel;
    word_t                    mom_sel;
    axis_t                    axis_inc;
    logic signed [ACC_W-1:0]  acc_w;
    mul_prod_t                gsum;
    gain_t                    g;
    logic signed [GAIN_W:0]   mom_diff;
    half_t                    h_next;
    wide_t                    prod_w;
    logic signed [DOT_W:0]    dsum;
    logic signed [DOT_W:0]    rsum;
    logic signed [GAIN_W:0]   e_diff;

    assign d_sel   = diff[axis_reg];
    assign mom_sel = mom_in[axis_reg];

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  axis_inc = AXIS_Y;
            default: axis_inc = AXIS_Z;
        endcase
    end

    // Next state: nine steps per axis, then energy rounding and update.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (start)
                    state_next = AR_MUL_LO;
            end
            AR_MUL_LO:  state_next = AR_MUL_HI;
            AR_MUL_HI:  state_next = AR_ACC;
            AR_ACC:     state_next = AR_MUL_RHO;
            AR_MUL_RHO: state_next = AR_GAIN;
            AR_GAIN:    state_next = AR_MUL_HLO;
            AR_MUL_HLO: state_next = AR_MUL_HHI;
            AR_MUL_HHI: state_next = AR_PROD;
            AR_PROD:    state_next = AR_DOT;
            AR_DOT:     state_next = (axis_reg == AXIS_Z) ? AR_RND : AR_MUL_LO;
            AR_RND:     state_next = AR_ENERGY;
            AR_ENERGY:  state_next = AR_DONE;
            AR_DONE:    state_next = AR_IDLE;
            default:    state_next = AR_IDLE;
        endcase
    end

    // Multiplier operand selection and done flag.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        done  = 1'b0;
        case (state_reg)
            AR_MUL_LO:
            begin
                mul_a = {1'b0, grav_scale};
                mul_b = {1'b0, d_sel[WORD_W-1:0]};
            end
            AR_MUL_HI:
            begin
                mul_a = {1'b0, grav_scale};
                mul_b = MUL_W'($signed(d_sel[DIFF_W-1:WORD_W]));
            end
            AR_MUL_RHO:
            begin
                mul_a = {2'b00, density};
                mul_b = MUL_W'(acc_reg);
            end
            AR_MUL_HLO:
            begin
                mul_a = MUL_W'(acc_reg);
                mul_b = {{(MUL_W-H_LO_W){1'b0}}, h_reg[H_LO_W-1:0]};
            end
            AR_MUL_HHI:
            begin
                mul_a = MUL_W'(acc_reg);
                mul_b = MUL_W'($signed(h_reg[H_W-1:H_LO_W]));
            end
            AR_DONE: done = 1'b1;
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Acceleration: round half up of grav_scale * D / 2^16 from two partial products.
    assign acc_w = (ACC_W'(mul_reg) <<< WORD_W) + ACC_W'(lo_reg) + ACC_W'(32768);

    // Momentum change: round half up of density * A / 2^16.
    assign gsum     = mul_reg + PROD_W'(32768);
    assign g        = gsum[GAIN_W+15:16];
    assign mom_diff = (GAIN_W+1)'(mom_sel) - (GAIN_W+1)'(g);
    assign h_next   = (H_W'(mom_sel) <<< 1) - H_W'(g);

    // A * h from two partial products, then the saturating dot sum.
    assign prod_w = (WIDE_W'(mul_reg) <<< H_LO_W) + WIDE_W'(lo_reg);
    assign dsum   = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(psat_reg);

    // Energy: round half up of the dot sum / 2^17.
    assign rsum   = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(65536);
    assign e_diff = (GAIN_W+1)'(energy_in) - (GAIN_W+1)'(rdot_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    axis_reg <= AXIS_X;
                    dot_reg  <= '0;
                end
            end
            AR_MUL_HI:  lo_reg  <= mul_reg;
            AR_ACC:     acc_reg <= sat32(WIDE_W'(acc_w >>> 16));
            AR_GAIN:
            begin
                mom_out_reg[axis_reg] <= sat32(WIDE_W'(mom_diff));
                h_reg                 <= h_next;
            end
            AR_MUL_HHI: lo_reg   <= mul_reg;
            AR_PROD:    psat_reg <= sat64(prod_w);
            AR_DOT:
            begin
                dot_reg  <= sat64(WIDE_W'(dsum));
                axis_reg <= axis_inc;
            end
            AR_RND:     rdot_reg       <= rsum[DOT_W:17];
            AR_ENERGY:  energy_out_reg <= sat32(WIDE_W'(e_diff));
            default:
            begin
            end
        endcase
    end

    assign mom_out    = mom_out_reg;
    assign energy_out = energy_out_reg;

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for gravity_momentum_energy_update: loads every readable cube word, then drives
// directed and random cell updates under several register settings and checks every result beat.
// Depends on gmeu_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
    import gmeu_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 40;
    localparam int MAX_PRINTED    = 30;

    localparam word_t W_MAX = 32'sh7FFF_FFFF;
    localparam word_t W_MIN = 32'sh8000_0000;
    localparam logic [RHO_W-1:0] RHO_MAX = '1;

    // One input beat, field by field.
    typedef struct packed {
        opcode_t          op;
        coord_t           x;
        coord_t           y;
        coord_t           z;
        word_t            pot;
        logic [RHO_W-1:0] rho;
        word_t            mom_x;
        word_t            mom_y;
        word_t            mom_z;
        word_t            energy;
    } gm_beat_t;

    // One output beat; mom_x sits in the lowest bits, as on m_tdata.
    typedef struct packed {
        word_t energy;
        word_t mom_z;
        word_t mom_y;
        word_t mom_x;
    } cell_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STARVED,
        RX_BUSY
    } rx_pattern_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Bench copy of the potential cube and of the registers.
    word_t        pot_mem [CUBE_WORDS];
    logic [31:0]  grav_cfg = '0;
    logic         five_cfg = 1'b0;

    gm_beat_t     beat_q[$];
    cell_result_t cell_update_q[$];
    gm_beat_t     cur_beat;

    int           burst_left  = 0;
    int           gap_left    = 0;
    rx_pattern_t  rx_pattern  = RX_OPEN;
    int           rx_left     = 0;
    int           cycle_count = 0;
    int           err_count   = 0;
    int           loads_taken = 0;
    int           cells_checked = 0;
    logic [127:0] got_bits;
    logic [127:0] want_bits;

    gravity_momentum_energy_update uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Clamp a wide signed value to a signed range of the given width.
    function automatic logic signed [127:0] clamp_signed(input logic signed [127:0] v,
                                                         input int bits);
        logic signed [127:0] top;
        top = (128'sd1 <<< (bits - 1)) - 128'sd1;
        if (v > top)
            return top;
        if (v < -top - 128'sd1)
            return -top - 128'sd1;
        return v;
    endfunction

    function automatic int cube_addr(input int x, input int y, input int z);
        return (z * CUBE_SIDE + y) * CUBE_SIDE + x;
    endfunction

    // A word is read by some interior cell when at least two of its coordinates lie inside.
    function automatic bit readable_word(input int x, input int y, input int z);
        int inner;
        inner = 0;
        if (x >= GHOST_WIDTH && x < GHOST_WIDTH + CELLS_PER_SIDE)
            inner++;
        if (y >= GHOST_WIDTH && y < GHOST_WIDTH + CELLS_PER_SIDE)
            inner++;
        if (z >= GHOST_WIDTH && z < GHOST_WIDTH + CELLS_PER_SIDE)
            inner++;
        return inner >= 2;
    endfunction

    // Acceleration along one axis: scaled central difference, rounded half up, saturated.
    function automatic longint axis_accel(input int cx, input int cy, input int cz,
                                          input int dx, input int dy, input int dz);
        longint              p1;
        longint              m1;
        longint              p2;
        longint              m2;
        longint              diff;
        logic signed [127:0] scale_w;
        logic signed [127:0] diff_w;
        logic signed [127:0] prod;
        p1 = pot_mem[cube_addr(cx + dx, cy + dy, cz + dz)];
        m1 = pot_mem[cube_addr(cx - dx, cy - dy, cz - dz)];
        if (five_cfg && FIVE_OK)
        begin
            p2 = pot_mem[cube_addr(cx + 2 * dx, cy + 2 * dy, cz + 2 * dz)];
            m2 = pot_mem[cube_addr(cx - 2 * dx, cy - 2 * dy, cz - 2 * dz)];
            diff = m2 - p2 + 8 * p1 - 8 * m1;
        end
        else
        begin
            diff = p1 - m1;
        end
        scale_w = {96'b0, grav_cfg};
        diff_w  = diff;
        prod    = (scale_w * diff_w + 128'sd32768) >>> 16;
        return longint'(clamp_signed(prod, 32));
    endfunction

    // Apply one accepted beat: a load updates the cube copy, an interior cell yields a result.
    task automatic absorb_beat(input gm_beat_t b);
        longint              rho;
        longint              g;
        longint              h;
        longint              mom [3];
        longint              acc [3];
        logic signed [127:0] wide_a;
        logic signed [127:0] wide_b;
        logic signed [127:0] dot;
        word_t               upd [3];
        cell_result_t        res;
        int                  cx;
        int                  cy;
        int                  cz;
        if (b.op == OP_LOAD)
        begin
            if (b.x < CUBE_SIDE && b.y < CUBE_SIDE && b.z < CUBE_SIDE)
            begin
                pot_mem[cube_addr(b.x, b.y, b.z)] = b.pot;
                loads_taken++;
            end
        end
        else if (b.x < CELLS_PER_SIDE && b.y < CELLS_PER_SIDE && b.z < CELLS_PER_SIDE)
        begin
            cx = b.x + GHOST_WIDTH;
            cy = b.y + GHOST_WIDTH;
            cz = b.z + GHOST_WIDTH;
            acc[0] = axis_accel(cx, cy, cz, 1, 0, 0);
            acc[1] = axis_accel(cx, cy, cz, 0, 1, 0);
            acc[2] = axis_accel(cx, cy, cz, 0, 0, 1);
            rho    = b.rho;
            mom[0] = b.mom_x;
            mom[1] = b.mom_y;
            mom[2] = b.mom_z;
            // Momentum kick per axis, and the a.(p + p') sum that drives the energy change.
            dot = '0;
            for (int i = 0; i < 3; i++)
            begin
                g      = (rho * acc[i] + 64'sd32768) >>> 16;
                h      = 2 * mom[i] - g;
                wide_a = mom[i] - g;
                upd[i] = word_t'(clamp_signed(wide_a, 32));
                wide_a = acc[i];
                wide_b = h;
                dot    = clamp_signed(dot + clamp_signed(wide_a * wide_b, 64), 64);
            end
            wide_a     = b.energy;
            wide_a     = wide_a - ((dot + 128'sd65536) >>> 17);
            res.mom_x  = upd[0];
            res.mom_y  = upd[1];
            res.mom_z  = upd[2];
            res.energy = word_t'(clamp_signed(wide_a, 32));
            cell_update_q.push_back(res);
        end
    endtask

    function automatic logic [S_TDATA_W-1:0] pack_beat(input gm_beat_t b);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[POS_X_LSB +: COORD_W]  = b.x;
        d[POS_Y_LSB +: COORD_W]  = b.y;
        d[POS_Z_LSB +: COORD_W]  = b.z;
        d[POT_LSB +: WORD_W]     = b.pot;
        d[RHO_LSB +: RHO_W]      = b.rho;
        d[MOM_X_LSB +: WORD_W]   = b.mom_x;
        d[MOM_Y_LSB +: WORD_W]   = b.mom_y;
        d[MOM_Z_LSB +: WORD_W]   = b.mom_z;
        d[ENERGY_LSB +: WORD_W]  = b.energy;
        return d;
    endfunction

    function automatic gm_beat_t make_load(input int x, input int y, input int z,
                                           input word_t pot);
        gm_beat_t b;
        b     = '0;
        b.op  = OP_LOAD;
        b.x   = coord_t'(x);
        b.y   = coord_t'(y);
        b.z   = coord_t'(z);
        b.pot = pot;
        return b;
    endfunction

    function automatic gm_beat_t make_cell(input int x, input int y, input int z,
                                           input logic [RHO_W-1:0] rho, input word_t mx,
                                           input word_t my, input word_t mz, input word_t e);
        gm_beat_t b;
        b        = '0;
        b.op     = OP_PROC;
        b.x      = coord_t'(x);
        b.y      = coord_t'(y);
        b.z      = coord_t'(z);
        b.rho    = rho;
        b.mom_x  = mx;
        b.mom_y  = my;
        b.mom_z  = mz;
        b.energy = e;
        return b;
    endfunction

    // Signed word spread over all magnitudes, with the extremes now and then.
    function automatic word_t pick_word();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return W_MAX;
                1:       return W_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [RHO_W-1:0] pick_rho();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RHO_MAX;
            default: return RHO_W'($urandom) >> $urandom_range(0, 30);
        endcase
    endfunction

    function automatic int pick_cell_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? CELLS_PER_SIDE - 1 : 0;
        return $urandom_range(0, CELLS_PER_SIDE - 1);
    endfunction

    // Queue one random run: mostly a few neighbor reloads followed by a cell update,
    // sometimes a stray load or an out-of-range beat. Returns the beats that do work.
    function automatic int queue_random_run();
        int c [3];
        int cell_pos [3];
        int n;
        int ax;
        int ofs;
        for (int i = 0; i < 3; i++)
            c[i] = $urandom_range(0, 15);
        case ($urandom_range(0, 11))
            0:
            begin
                c[$urandom_range(0, 2)] = $urandom_range(CUBE_SIDE, 15);
                beat_q.push_back(make_load(c[0], c[1], c[2], pick_word()));
                return 0;
            end
            1:
            begin
                c[$urandom_range(0, 2)] = $urandom_range(CELLS_PER_SIDE, 15);
                beat_q.push_back(make_cell(c[0], c[1], c[2], pick_rho(), pick_word(),
                                           pick_word(), pick_word(), pick_word()));
                return 0;
            end
            2:
            begin
                beat_q.push_back(make_load($urandom_range(0, CUBE_SIDE - 1),
                                           $urandom_range(0, CUBE_SIDE - 1),
                                           $urandom_range(0, CUBE_SIDE - 1), pick_word()));
                return 1;
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    cell_pos[i] = pick_cell_coord();
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
                for (int k = 0; k < n; k++)
                begin
                    for (int i = 0; i < 3; i++)
                        c[i] = cell_pos[i] + GHOST_WIDTH;
                    ax  = $urandom_range(0, 2);
                    ofs = $urandom_range(1, GHOST_WIDTH);
                    if ($urandom_range(0, 1))
                        ofs = -ofs;
                    c[ax] += ofs;
                    beat_q.push_back(make_load(c[0], c[1], c[2], pick_word()));
                end
                beat_q.push_back(make_cell(cell_pos[0], cell_pos[1], cell_pos[2], pick_rho(),
                                           pick_word(), pick_word(), pick_word(),
                                           pick_word()));
                return n + 1;
            end
        endcase
    endfunction

    // Register write followed by a read-back through the configuration port.
    task automatic set_reg(input reg_index_t idx, input logic [31:0] val);
        logic [31:0] got;
        logic [31:0] want;
        want = (idx == REG_FIVE_POINT) ? {31'b0, val[0]} : val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_GRAV_SCALE)
            grav_cfg = val;
        else
            five_cfg = val[0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report_mismatch($sformatf("register %s read back %h, want %h",
                                      idx.name(), got, want));
    endtask

    // Wait until every beat is taken and every result is back, then let the block settle.
    task automatic wait_idle();
        while (beat_q.size() != 0 || s_tvalid || cell_update_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_beat(cur_beat);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    cur_beat  = beat_q.pop_front();
                    s_tdata  <= pack_beat(cur_beat);
                    s_tuser  <= cur_beat.op;
                    s_tvalid <= 1'b1;
                    if (burst_left != 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls on a pattern that changes now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_left    = 0;
            rx_pattern = RX_OPEN;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_bits = m_tdata;
                if (cell_update_q.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %h with no cell update pending",
                                              got_bits));
                end
                else
                begin
                    want_bits = cell_update_q.pop_front();
                    cells_checked++;
                    for (int f = 0; f < 4; f++)
                    begin
                        if (got_bits[32 * f +: 32] !== want_bits[32 * f +: 32])
                            report_mismatch($sformatf("cell %0d %s: got %h, want %h",
                                cells_checked,
                                (f == 0) ? "mom_x_out" : (f == 1) ? "mom_y_out" :
                                (f == 2) ? "mom_z_out" : "energy_out",
                                got_bits[32 * f +: 32], want_bits[32 * f +: 32]));
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left    = $urandom_range(16, 160);
            end
            else
            begin
                rx_left--;
            end
            case (rx_pattern)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_STARVED: m_tready <= ($urandom_range(0, 7) == 0);
                default:    m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [31:0] gs;
        logic        fp;
        int          useful;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Unit scale, two-point gradient; load every word that an interior cell can read.
        set_reg(REG_GRAV_SCALE, 32'h0001_0000);
        set_reg(REG_FIVE_POINT, 32'h0);
        @(negedge clk);
        for (int z = 0; z < CUBE_SIDE; z++)
            for (int y = 0; y < CUBE_SIDE; y++)
                for (int x = 0; x < CUBE_SIDE; x++)
                    if (readable_word(x, y, z))
                        beat_q.push_back(make_load(x, y, z, pick_word()));

        // Directed: interior corners, field extremes, zero density, dropped beats, steep slope.
        beat_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 32'sh0000_8000, 32'shFFFF_8000,
                                   32'sh0, 32'sh0010_0000));
        beat_q.push_back(make_cell(7, 7, 7, RHO_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        beat_q.push_back(make_cell(0, 7, 0, '0, W_MIN, W_MIN, W_MIN, W_MIN));
        beat_q.push_back(make_cell(7, 0, 7, RHO_MAX, W_MIN, W_MAX, '1, W_MIN));
        beat_q.push_back(make_load(CUBE_SIDE, 0, 0, W_MAX));
        beat_q.push_back(make_load(0, 15, 0, W_MIN));
        beat_q.push_back(make_load(5, 5, 13, W_MAX));
        beat_q.push_back(make_cell(CELLS_PER_SIDE, 0, 0, RHO_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        beat_q.push_back(make_cell(0, 9, 0, RHO_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        beat_q.push_back(make_cell(0, 0, 15, RHO_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        beat_q.push_back(make_cell(15, 15, 15, RHO_MAX, W_MIN, W_MIN, W_MIN, W_MIN));
        beat_q.push_back(make_load(0, 0, 0, W_MIN));
        beat_q.push_back(make_load(CUBE_SIDE - 1, CUBE_SIDE - 1, CUBE_SIDE - 1, W_MAX));
        beat_q.push_back(make_load(0, 2, 2, W_MIN));
        beat_q.push_back(make_load(1, 2, 2, W_MIN));
        beat_q.push_back(make_load(3, 2, 2, W_MAX));
        beat_q.push_back(make_load(4, 2, 2, W_MAX));
        beat_q.push_back(make_cell(0, 0, 0, RHO_MAX, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        beat_q.push_back(make_cell(0, 0, 0, 31'h0000_0100, W_MAX, W_MIN, 32'sh1, W_MAX));
        wait_idle();

        // Random runs under a series of settings, the extremes among them.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin gs = 32'hFFFF_FFFF;                     fp = 1'b1; end
                1:       begin gs = 32'h0;                             fp = 1'b0; end
                2:       begin gs = 32'h1;                             fp = 1'b1; end
                3:       begin gs = $urandom >> $urandom_range(0, 31); fp = 1'b0; end
                4:       begin gs = $urandom >> $urandom_range(8, 24); fp = 1'b1; end
                default: begin gs = 32'h0000_1555;                     fp = 1'b1; end
            endcase
            set_reg(REG_GRAV_SCALE, gs);
            set_reg(REG_FIVE_POINT, {31'b0, fp});
            @(negedge clk);
            useful = 0;
            while (useful < PHASE_ITEMS)
                useful += queue_random_run();
            wait_idle();
        end

        $display("Covered %0d potential loads and %0d checked cell updates under %0d settings.",
                 loads_taken, cells_checked, RANDOM_PHASES + 1);
        $display("Mismatches counted: %0d", err_count);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit.
    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
            @(posedge clk);
        $display("Timed out with %0d beats queued and %0d results outstanding.",
                 beat_q.size(), cell_update_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
